// File: rtl/aabbt_pkg.sv
// Shared types and constants for the box transform pipeline.
package aabbt_pkg;

  localparam int CornerCount = 8;
  localparam int CntW        = 3;
  localparam int QW          = 32;
  localparam int PW          = 64;
  localparam int SW          = 50;
  localparam int MW          = 49;
  localparam int QBits       = 33;
  localparam int NumRegs     = 8;
  localparam int RegW        = 64;
  localparam int IdxW        = 3;

  localparam logic [QW-1:0] QMax = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] QMin = 32'h8000_0000;

  localparam logic [NumRegs-1:0][RegW-1:0] MatReset = {
    64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic [2:0][QW-1:0]    p;
  } corner_t;

  typedef struct packed {
    logic [MW-1:0]    r;
    logic [QBits-1:0] d;
    logic [QBits-1:0] q;
    logic             neg;
    logic             sat;
    logic             nzero;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [MW-1:0]    w;
    lane_t [2:0]      lane;
  } div_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic               err;
    logic [2:0][QW-1:0] q;
  } res_t;

endpackage

// File: rtl/aabbt_corner_seq.sv
// Box capture and corner sequencer: one corner per advancing cycle.
module aabbt_corner_seq (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  adv_i,
  input  logic                                  req_valid_i,
  output logic                                  req_ready_o,
  input  logic [5:0][aabbt_pkg::QW-1:0]         box_i,
  output aabbt_pkg::corner_t                    corner_o
);

  logic                               busy_q, busy_d;
  logic [aabbt_pkg::CntW-1:0]         cnt_q, cnt_d;
  logic [5:0][aabbt_pkg::QW-1:0]      box_q;
  logic                               last_c;
  logic                               accept_c;

  assign last_c      = (cnt_q == aabbt_pkg::CntW'(aabbt_pkg::CornerCount - 1));
  assign req_ready_o = !busy_q || (last_c && adv_i);
  assign accept_c    = req_valid_i && req_ready_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (accept_c) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q && adv_i) begin
      busy_d = !last_c;
      cnt_d  = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_c) begin
      box_q <= box_i;
    end
  end

  always_comb begin
    corner_o.valid = busy_q;
    corner_o.last  = last_c;
    for (int a = 0; a < 3; a++) begin
      corner_o.p[a] = cnt_q[a] ? box_q[3+a] : box_q[a];
    end
  end

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !last_c |-> !req_ready_o) else $error("request taken mid box");
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_c |=> busy_q && cnt_q == '0) else $error("box start lost");
  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0) else $error("count off while idle");

endmodule

// File: rtl/aabbt_xform.sv
// Corner times matrix: products, column sums, divider setup.
module aabbt_xform (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  aabbt_pkg::corner_t                  corner_i,
  input  logic [15:0][aabbt_pkg::QW-1:0]      mat_i,
  output aabbt_pkg::div_t                     div_o
);

  logic                                     v1_q, l1_q, v2_q, l2_q;
  logic signed [aabbt_pkg::PW-1:0]          prod_q [4][3];
  logic signed [aabbt_pkg::QW-1:0]          trans_q [4];
  logic signed [aabbt_pkg::SW-1:0]          t_q [4];
  logic signed [aabbt_pkg::SW-1:0]          t_d [4];
  aabbt_pkg::div_t                          div_q, div_d;

  always_comb begin
    logic signed [aabbt_pkg::PW-1:0] s;
    for (int c = 0; c < 4; c++) begin
      s = aabbt_pkg::PW'(trans_q[c]);
      for (int a = 0; a < 3; a++) begin
        s = s + (prod_q[c][a] >>> 16);
      end
      t_d[c] = s[aabbt_pkg::SW-1:0];
    end
  end

  always_comb begin
    logic [aabbt_pkg::SW-1:0] nabs, wabs;
    wabs = t_q[3][aabbt_pkg::SW-1] ? aabbt_pkg::SW'(-t_q[3]) : t_q[3];
    div_d.valid = v2_q;
    div_d.last  = l2_q;
    div_d.w     = wabs[aabbt_pkg::MW-1:0];
    for (int a = 0; a < 3; a++) begin
      nabs = t_q[a][aabbt_pkg::SW-1] ? aabbt_pkg::SW'(-t_q[a]) : t_q[a];
      div_d.lane[a].neg   = t_q[a][aabbt_pkg::SW-1] ^ t_q[3][aabbt_pkg::SW-1];
      div_d.lane[a].nzero = (t_q[a] == '0);
      div_d.lane[a].sat   = ({17'b0, nabs[aabbt_pkg::MW-1:0]} >=
                             {wabs[aabbt_pkg::MW-1:0], 17'b0});
      div_d.lane[a].r     = aabbt_pkg::MW'(nabs[aabbt_pkg::MW-1:17]);
      div_d.lane[a].d     = {nabs[16:0], 16'b0};
      div_d.lane[a].q     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      div_q <= '0;
    end else if (adv_i) begin
      v1_q  <= corner_i.valid;
      v2_q  <= v1_q;
      div_q <= div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      l1_q <= corner_i.last;
      l2_q <= l1_q;
      for (int c = 0; c < 4; c++) begin
        trans_q[c] <= $signed(mat_i[12+c]);
        t_q[c]     <= t_d[c];
        for (int a = 0; a < 3; a++) begin
          prod_q[c][a] <= $signed(corner_i.p[a]) * $signed(mat_i[a*4+c]);
        end
      end
    end
  end

  always_comb begin
    div_o       = div_q;
    div_o.valid = div_q.valid;
  end

endmodule

// File: rtl/aabbt_div.sv
// Restoring divider, one quotient bit per stage, then saturation.
module aabbt_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  aabbt_pkg::div_t  div_i,
  output aabbt_pkg::res_t  res_o
);

  aabbt_pkg::div_t st_q [1:aabbt_pkg::QBits];
  aabbt_pkg::div_t st_d [aabbt_pkg::QBits];
  aabbt_pkg::res_t res_q, res_d;

  for (genvar i = 0; i < aabbt_pkg::QBits; i++) begin : g_stage
    aabbt_pkg::div_t src;

    if (i == 0) begin : g_head
      assign src = div_i;
    end else begin : g_body
      assign src = st_q[i];
    end

    always_comb begin
      logic [aabbt_pkg::MW:0] rs;
      st_d[i] = src;
      for (int a = 0; a < 3; a++) begin
        rs = {src.lane[a].r, src.lane[a].d[aabbt_pkg::QBits-1]};
        st_d[i].lane[a].d = {src.lane[a].d[aabbt_pkg::QBits-2:0], 1'b0};
        if (rs >= {1'b0, src.w}) begin
          st_d[i].lane[a].r = aabbt_pkg::MW'(rs - {1'b0, src.w});
          st_d[i].lane[a].q = {src.lane[a].q[aabbt_pkg::QBits-2:0], 1'b1};
        end else begin
          st_d[i].lane[a].r = rs[aabbt_pkg::MW-1:0];
          st_d[i].lane[a].q = {src.lane[a].q[aabbt_pkg::QBits-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= aabbt_pkg::QBits; i++) begin
        st_q[i] <= '0;
      end
    end else if (adv_i) begin
      for (int i = 1; i <= aabbt_pkg::QBits; i++) begin
        st_q[i] <= st_d[i-1];
      end
    end
  end

  always_comb begin
    aabbt_pkg::lane_t ln;
    res_d.valid = st_q[aabbt_pkg::QBits].valid;
    res_d.last  = st_q[aabbt_pkg::QBits].last;
    res_d.err   = 1'b0;
    for (int a = 0; a < 3; a++) begin
      ln = st_q[aabbt_pkg::QBits].lane[a];
      if (ln.sat) begin
        res_d.err = 1'b1;
        res_d.q[a] = ln.nzero ? '0 : (ln.neg ? aabbt_pkg::QMin : aabbt_pkg::QMax);
      end else if (ln.neg) begin
        if (ln.q > {1'b0, aabbt_pkg::QMin}) begin
          res_d.err  = 1'b1;
          res_d.q[a] = aabbt_pkg::QMin;
        end else begin
          res_d.q[a] = aabbt_pkg::QW'(-ln.q);
        end
      end else if (ln.q > {1'b0, aabbt_pkg::QMax}) begin
        res_d.err  = 1'b1;
        res_d.q[a] = aabbt_pkg::QMax;
      end else begin
        res_d.q[a] = ln.q[aabbt_pkg::QW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/aabbt_minmax.sv
// Running per-axis min/max over a box's corners and the output register.
module aabbt_minmax (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aabbt_pkg::res_t               res_i,
  output logic                          adv_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [5:0][aabbt_pkg::QW-1:0] out_box_o,
  output logic                          out_err_o
);

  logic                               first_q;
  logic [aabbt_pkg::CntW-1:0]         cnt_q;
  logic [2:0][aabbt_pkg::QW-1:0]      min_q, max_q, min_d, max_d;
  logic                               err_q, err_d;
  logic                               out_valid_q;
  logic [5:0][aabbt_pkg::QW-1:0]      out_box_q;
  logic                               out_err_q;
  logic                               take_c;

  assign adv_o  = !out_valid_q || out_ready_i;
  assign take_c = adv_o && res_i.valid;

  always_comb begin
    err_d = res_i.err || (!first_q && err_q);
    for (int a = 0; a < 3; a++) begin
      min_d[a] = (first_q || ($signed(res_i.q[a]) < $signed(min_q[a]))) ? res_i.q[a]
                                                                         : min_q[a];
      max_d[a] = (first_q || ($signed(res_i.q[a]) > $signed(max_q[a]))) ? res_i.q[a]
                                                                         : max_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_c) begin
        first_q <= res_i.last;
        cnt_q   <= cnt_q + 1'b1;
      end
      if (take_c && res_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_c) begin
      min_q <= min_d;
      max_q <= max_d;
      err_q <= err_d;
      if (res_i.last) begin
        out_box_q <= {max_d, min_d};
        out_err_q <= err_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_box_o   = out_box_q;
  assign out_err_o   = out_err_q;

  a_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_c && res_i.last |-> cnt_q == aabbt_pkg::CntW'(aabbt_pkg::CornerCount - 1))
    else $error("box closed on wrong corner");
  a_first_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q |-> cnt_q == '0) else $error("corner count out of step");

endmodule

// File: rtl/aabb_transform.sv
// Top level: axis-aligned box transform by a 4x4 Q16.16 matrix.
//
// Slave stream takes one box request (min and max corners, signed Q16.16).
// Master stream returns the transformed box and a range error flag in tuser.
// Config port writes the eight 64-bit matrix registers, each holding two
// Q16.16 entries; write only while no box is in flight.
// Each box is expanded into eight corners, one per cycle while the pipeline
// advances; the corner sequencer takes the next request with the last corner.
// Each corner goes through 12 parallel 32x32 multipliers, a column sum, a
// divider setup stage, a 33-stage restoring divider (one bit per stage),
// a saturation stage and the min/max accumulator.
// Reset loads the identity matrix and empties the pipeline.
// When the receiver stalls the result holds in the output register; the
// whole pipeline freezes and resumes without loss. A new request is still
// taken into the sequencer while a result waits, if the sequencer is free.
module aabb_transform (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
  output logic [191:0] m_axis_tdata,
  // range_error
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [aabbt_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [aabbt_pkg::RegW-1:0] cfg_data_i
);

  logic [aabbt_pkg::NumRegs-1:0][aabbt_pkg::RegW-1:0] mat_q;
  logic [15:0][aabbt_pkg::QW-1:0]                      mat_c;
  logic                                                adv_c;
  aabbt_pkg::corner_t                                  corner_c;
  aabbt_pkg::div_t                                     div_c;
  aabbt_pkg::res_t                                     res_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= aabbt_pkg::MatReset;
    end else if (cfg_we_i) begin
      mat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat_c[r*4+c] = mat_q[r*2 + c/2][(c%2)*32 +: 32];
      end
    end
  end

  aabbt_corner_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv_c),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .box_i       (s_axis_tdata),
    .corner_o    (corner_c)
  );

  aabbt_xform u_xform (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv_c),
    .corner_i (corner_c),
    .mat_i    (mat_c),
    .div_o    (div_c)
  );

  aabbt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv_c),
    .div_i  (div_c),
    .res_o  (res_c)
  );

  aabbt_minmax u_minmax (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res_c),
    .adv_o       (adv_c),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_box_o   (m_axis_tdata),
    .out_err_o   (m_axis_tuser)
  );

endmodule

// File: verif/aabb_transform_tb.sv
// Testbench for aabb_transform: matrix box transform checked against a built-in predictor.
`timescale 1ns / 1ps

module aabb_transform_tb;

  localparam int SettleCycles = 60;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic err;
    logic [5:0][aabbt_pkg::QW-1:0] box;
  } box_result_t;

  typedef enum logic [aabbt_pkg::IdxW-1:0] {
    R0C01 = 3'd0, R0C23 = 3'd1, R1C01 = 3'd2, R1C23 = 3'd3,
    R2C01 = 3'd4, R2C23 = 3'd5, R3C01 = 3'd6, R3C23 = 3'd7
  } mat_reg_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [aabbt_pkg::IdxW-1:0] cfg_idx_i = '0;
  logic [aabbt_pkg::RegW-1:0] cfg_data_i = '0;

  logic [aabbt_pkg::RegW-1:0] matrix [aabbt_pkg::NumRegs];
  box_result_t expected_boxes [$];
  int errors = 0;
  int idle_pct = 11;
  bit rx_hold = 1'b0;
  int quiet_cycles = 0;

  aabb_transform dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint entry(int row, int col);
    logic [aabbt_pkg::RegW-1:0] r;
    r = matrix[row * 2 + col / 2];
    return (col % 2) ? longint'(signed'(r[63:32])) : longint'(signed'(r[31:0]));
  endfunction

  function automatic longint divide_by_w(longint n, longint w, ref bit err);
    longint unsigned mn, mw, q;
    bit neg;
    if (w == 0) begin
      err = 1'b1;
      return (n > 0) ? 64'sd2147483647 : (n < 0) ? -64'sd2147483648 : 0;
    end
    mn = (n < 0) ? -n : n;
    mw = (w < 0) ? -w : w;
    neg = (n < 0) != (w < 0);
    q = (mn << 16) / mw;
    if (neg) begin
      if (q > 64'd2147483648) begin
        err = 1'b1;
        return -64'sd2147483648;
      end
      return -longint'(q);
    end
    if (q > 64'd2147483647) begin
      err = 1'b1;
      return 64'sd2147483647;
    end
    return longint'(q);
  endfunction

  function automatic box_result_t transform_box(logic [191:0] data);
    box_result_t res;
    longint lo [3], hi [3], bmin [3], bmax [3], p [3], t [4], q, s;
    bit err;
    err = 1'b0;
    for (int a = 0; a < 3; a++) begin
      lo[a] = longint'(signed'(data[a*32 +: 32]));
      hi[a] = longint'(signed'(data[(a+3)*32 +: 32]));
      bmin[a] = 64'sd2147483647;
      bmax[a] = -64'sd2147483648;
    end
    for (int k = 0; k < aabbt_pkg::CornerCount; k++) begin
      for (int a = 0; a < 3; a++) p[a] = k[a] ? hi[a] : lo[a];
      for (int c = 0; c < 4; c++) begin
        s = entry(3, c);
        for (int a = 0; a < 3; a++) s += (p[a] * entry(a, c)) >>> 16;
        t[c] = s;
      end
      for (int a = 0; a < 3; a++) begin
        q = divide_by_w(t[a], t[3], err);
        if (q < bmin[a]) bmin[a] = q;
        if (q > bmax[a]) bmax[a] = q;
      end
    end
    for (int a = 0; a < 3; a++) begin
      res.box[a] = bmin[a][31:0];
      res.box[a+3] = bmax[a][31:0];
    end
    res.err = err;
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %08h expected %08h", what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      box_result_t want;
      if (expected_boxes.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        want = expected_boxes.pop_front();
        for (int f = 0; f < 6; f++)
          if (m_axis_tdata[f*32 +: 32] !== want.box[f])
            report($sformatf("field %0d", f), m_axis_tdata[f*32 +: 32], want.box[f]);
        if (m_axis_tuser !== want.err) report("range_error", m_axis_tuser, want.err);
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_box(logic [191:0] data);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    expected_boxes.push_back(transform_box(data));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(mat_reg_e idx, logic [aabbt_pkg::RegW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    matrix[idx] = value;
    @(posedge clk_i);
  endtask

  task automatic load_matrix(logic [aabbt_pkg::NumRegs-1:0][aabbt_pkg::RegW-1:0] m);
    drain();
    for (int i = 0; i < aabbt_pkg::NumRegs; i++) write_reg(mat_reg_e'(i), m[i]);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] coord(int mode);
    case (mode)
      0: return 32'(signed'($urandom_range(2 * 65536 * 64)) - 65536 * 64);
      1: return 32'(signed'($urandom_range(2 * 65536)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [191:0] random_box(int mode);
    logic [191:0] d;
    logic [31:0] a, b;
    for (int i = 0; i < 3; i++) begin
      a = coord(mode);
      b = coord(mode);
      if ($urandom_range(9) != 0 && signed'(a) > signed'(b)) {a, b} = {b, a};
      d[i*32 +: 32] = a;
      d[(i+3)*32 +: 32] = b;
    end
    return d;
  endfunction

  function automatic logic [31:0] q_entry(int mode);
    case (mode)
      0: return 32'(signed'($urandom_range(4 * 65536)) - 2 * 65536);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [aabbt_pkg::NumRegs-1:0][aabbt_pkg::RegW-1:0] random_matrix(
      int mode, bit affine);
    logic [aabbt_pkg::NumRegs-1:0][aabbt_pkg::RegW-1:0] m;
    for (int i = 0; i < aabbt_pkg::NumRegs; i++) m[i] = {q_entry(mode), q_entry(mode)};
    if (affine) begin
      m[R0C23][63:32] = 32'h0;
      m[R1C23][63:32] = 32'h0;
      m[R2C23][63:32] = 32'h0;
      m[R3C23][63:32] = 32'h0001_0000;
    end
    return m;
  endfunction

  task automatic test_identity_extremes();
    logic [31:0] ext [5];
    ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000};
    for (int i = 0; i < 5; i++) send_box({6{ext[i]}});
    send_box({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_box({32'h0002_0000, 32'hFFFE_0000, 32'h0003_8000,
              32'h0005_0000, 32'h0001_0000, 32'hFFFF_0000});
  endtask

  task automatic test_special_matrices();
    logic [aabbt_pkg::NumRegs-1:0][aabbt_pkg::RegW-1:0] m;
    // zero w everywhere
    load_matrix(random_matrix(0, 1'b1));
    write_reg(R3C23, {32'h0, matrix[R3C23][31:0]});
    cfg_we_i <= 1'b0;
    send_box(random_box(1));
    send_box('0);
    // scaling that saturates, plus a negative w
    m = aabbt_pkg::MatReset;
    m[R0C01] = 64'h0000_0000_7FFF_FFFF;
    m[R3C23] = 64'hFFFF_0000_0000_0000;
    load_matrix(m);
    send_box({6{32'h0100_0000}});
    send_box(random_box(1));
    // most negative entries, small w
    load_matrix({aabbt_pkg::NumRegs{64'h8000_0000_8000_0000}});
    send_box({6{32'h7FFF_FFFF}});
    send_box(random_box(2));
    load_matrix({aabbt_pkg::NumRegs{64'hFFFF_FFFF_FFFF_FFFF}});
    send_box(random_box(2));
    send_box({6{32'h0000_0001}});
  endtask

  task automatic test_random_boxes();
    for (int phase = 0; phase < 10; phase++) begin
      load_matrix(random_matrix(phase % 3 == 2, phase % 2 == 0));
      idle_pct = (phase == 4) ? 0 : 11;
      for (int n = 0; n < 110; n++) send_box(random_box($urandom_range(2)));
    end
    idle_pct = 11;
  endtask

  task automatic test_backpressure();
    load_matrix(random_matrix(0, 1'b1));
    fork
      begin
        rx_hold = 1'b1;
        repeat (600) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      for (int n = 0; n < 20; n++) send_box(random_box(1));
    join
    drain();
    for (int n = 0; n < 5; n++) send_box(random_box(0));
  endtask

  initial begin
    for (int i = 0; i < aabbt_pkg::NumRegs; i++) matrix[i] = aabbt_pkg::MatReset[i];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity_extremes();
    test_special_matrices();
    test_backpressure();
    test_random_boxes();
    drain();
    if (errors == 0 && expected_boxes.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
rtl/aabbt_pkg.sv
rtl/aabbt_corner_seq.sv
rtl/aabbt_xform.sv
rtl/aabbt_div.sv
rtl/aabbt_minmax.sv
rtl/aabb_transform.sv
verif/aabb_transform_tb.sv
